/* rtl/core/rtt_pkg.sv */
// Range translation table: shared constants, opcodes and the controller/datapath
// command and status bundles. No dependencies.

package rtt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int VAL_W   = 32;
    localparam int MAP_W   = 33;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] dest;
        logic [VAL_W-1:0] src;
        logic [VAL_W-1:0] span;
    } entry_t;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_step;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic write_new;
        logic clear;
        logic set_full;
        logic set_miss;
        logic set_hit;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       srch_done;
        logic       found;
        logic       shift_done;
    } dp_stat_t;

endpackage

/* rtl/core/rtt_datapath.sv */
// Range translation table datapath: request registers, entry memory, search bounds,
// shift index and result registers. Depends on rtt_pkg.

module rtt_datapath
    import rtt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         op,
    input  logic [VAL_W-1:0]   dest_start,
    input  logic [VAL_W-1:0]   src_start,
    input  logic [VAL_W-1:0]   span,
    input  logic [VAL_W-1:0]   key,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic [MAP_W-1:0]   mapped,
    output logic               hit,
    output logic               status
);

    entry_t             mem [ENTRIES];
    entry_t             rdata_reg;

    logic [1:0]         op_reg;
    logic [VAL_W-1:0]   dest_reg;
    logic [VAL_W-1:0]   src_reg;
    logic [VAL_W-1:0]   span_reg;
    logic [VAL_W-1:0]   key_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   hi_reg;
    logic [IDX_W-1:0]   mid_reg;
    logic [CNT_W-1:0]   idx_reg;

    logic [MAP_W-1:0]   mapped_reg;
    logic               hit_reg;
    logic               status_reg;

    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [CNT_W-1:0]   idx_dec;
    logic [IDX_W-1:0]   rd_addr;
    logic [MAP_W-1:0]   end_v;
    logic               key_ge_end;
    logic               key_lt_base;
    logic               go_right;
    logic [MAP_W-1:0]   hit_val;

    // midpoint of [lo, hi) biased low, as lo + (hi - 1 - lo) / 2
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid     = mid_sum[IDX_W:1];
    assign idx_dec = idx_reg - 1'b1;
    assign rd_addr = cmd.shift_rd ? idx_dec[IDX_W-1:0] : mid;

    assign end_v       = {1'b0, rdata_reg.src} + {1'b0, rdata_reg.span};
    assign key_ge_end  = {1'b0, key_reg} >= end_v;
    assign key_lt_base = key_reg < rdata_reg.src;
    assign go_right    = (op_reg == OP_INSERT) ? (rdata_reg.src <= src_reg) : key_ge_end;
    assign hit_val     = {1'b0, rdata_reg.dest} + {1'b0, key_reg - rdata_reg.src};

    assign stat.op         = op_reg;
    assign stat.full       = count_reg == CNT_W'(ENTRIES);
    assign stat.srch_done  = lo_reg >= hi_reg;
    assign stat.found      = !key_ge_end && !key_lt_base;
    assign stat.shift_done = idx_reg == lo_reg;

    assign mapped = mapped_reg;
    assign hit    = hit_reg;
    assign status = status_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.srch_rd || cmd.shift_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.shift_wr)
        begin
            mem[idx_reg[IDX_W-1:0]] <= rdata_reg;
        end
        else if (cmd.write_new)
        begin
            mem[lo_reg[IDX_W-1:0]] <= '{dest: dest_reg, src: src_reg, span: span_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            dest_reg <= dest_start;
            src_reg  <= src_start;
            span_reg <= span;
            key_reg  <= key;
        end
        if (cmd.srch_rd)
        begin
            mid_reg <= mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            idx_reg    <= '0;
            mapped_reg <= '0;
            hit_reg    <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                lo_reg     <= '0;
                hi_reg     <= count_reg;
                mapped_reg <= '0;
                hit_reg    <= 1'b0;
                status_reg <= 1'b0;
            end
            else if (cmd.srch_step)
            begin
                if (go_right)
                begin
                    lo_reg <= CNT_W'(mid_reg) + 1'b1;
                end
                else
                begin
                    hi_reg <= CNT_W'(mid_reg);
                end
            end

            if (cmd.shift_init)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.shift_wr)
            begin
                idx_reg <= idx_dec;
            end

            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.write_new)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.set_full)
            begin
                status_reg <= 1'b1;
            end
            if (cmd.set_miss)
            begin
                mapped_reg <= {1'b0, key_reg};
            end
            else if (cmd.set_hit)
            begin
                mapped_reg <= hit_val;
                hit_reg    <= 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the table by one");

    a_step_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("search step outside live bounds");

endmodule

/* rtl/core/rtt_ctrl.sv */
// Range translation table controller: sequences search, shift and write steps
// and issues datapath commands. Depends on rtt_pkg.

module rtt_ctrl
    import rtt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.op == OP_INSERT)
                begin
                    if (stat.full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
                else if (stat.op == OP_LOOKUP)
                begin
                    state_next = S_SRCH_RD;
                end
                else if (stat.op == OP_CLEAR)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH_RD:
            begin
                if (stat.srch_done)
                begin
                    if (stat.op == OP_LOOKUP)
                    begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT_RD;
                    end
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.op == OP_LOOKUP && stat.found)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe lasted more than one cycle");

    a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && $past(cmd.load)))
        else $error("request not taken");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |=> done)
        else $error("insert write not followed by result");

endmodule

/* rtl/core/range_translation_table_core.sv */
// Range translation table top level: joins the controller and the datapath.
// Depends on rtt_pkg, rtt_ctrl and rtt_datapath.
//
// Holds up to 64 range entries sorted by source start. Raise start with op and its
// operands while busy is low; one request is taken per idle period. Exactly one result
// follows per request, shown on mapped/hit/status for the single cycle in which done
// is high; there is no back-pressure, so the receiver must take it then. The
// single-port entry memory gives one read per search step, which reads the midpoint entry
// and then compares it with the key. A lookup ends on a hit or, on a miss, when the bounds
// meet; a search takes up to 7 steps for a full table. An insert finds its slot, moves the
// entries above it up one place and writes the new entry; clear, a refused insert and an
// unused op go straight to done. busy drops the cycle after done.

module range_translation_table_core
    import rtt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         op,
    input  logic [VAL_W-1:0]   dest_start,
    input  logic [VAL_W-1:0]   src_start,
    input  logic [VAL_W-1:0]   span,
    input  logic [VAL_W-1:0]   key,
    output logic               busy,
    output logic               done,
    output logic [MAP_W-1:0]   mapped,
    output logic               hit,
    output logic               status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rtt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    rtt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .dest_start (dest_start),
        .src_start  (src_start),
        .span       (span),
        .key        (key),
        .cmd        (cmd),
        .stat       (stat),
        .mapped     (mapped),
        .hit        (hit),
        .status     (status)
    );

endmodule
